@@ hdl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round tables of the sha-256 digest core.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned DIGEST_WORDS = 8;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // byte source for the block shift line
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_MARK = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  localparam logic [31:0] SHA_IV [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       shift;
    logic [1:0] src;
    logic       count_inc;
    logic       comp_load;
    logic       round_en;
    logic [5:0] rnd;
    logic       ffwd;
    logic       init;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ hdl/sha256_dp.sv @@
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: block shift line doubling as schedule window, round registers,
// chaining words, fill and byte counters.
// ----------------------------------------------------------------------------
module sha256_dp
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [7:0]  data_byte,
  output sts_t        sts,
  output logic [31:0] digest_word
);

  logic [511:0] win_r, win_nxt;
  logic [31:0]  v_r [8];
  logic [31:0]  hv_r [8];
  logic [5:0]   fill_r;
  logic [63:0]  cnt_r;

  logic [63:0]  bits;
  logic [7:0]   len_byte;
  logic [7:0]   shift_byte;
  logic [31:0]  w0, w1, w9, w14, s0, s1, w_new;
  logic [31:0]  big0, big1, ch, maj, t1, t2;

  assign bits     = {cnt_r[60:0], 3'b000};
  assign len_byte = bits[{~fill_r[2:0], 3'b000} +: 8];

  always_comb begin
    case (cmd.src)
      SRC_DATA: shift_byte = data_byte;
      SRC_MARK: shift_byte = PAD_MARK;
      SRC_LEN:  shift_byte = len_byte;
      default:  shift_byte = 8'h00;
    endcase
  end

  assign w0    = win_r[511:480];
  assign w1    = win_r[479:448];
  assign w9    = win_r[223:192];
  assign w14   = win_r[63:32];
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;

  assign big1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + big1 + ch + SHA_K[cmd.rnd] + w0;
  assign big0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2   = big0 + maj;

  always_comb begin
    win_nxt = win_r;
    if (cmd.shift) begin
      win_nxt = {win_r[503:0], shift_byte};
    end else if (cmd.round_en) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (cmd.comp_load) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= hv_r[i];
      end
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      for (int i = 0; i < 8; i++) begin
        hv_r[i] <= SHA_IV[i];
      end
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.ffwd) begin
        for (int i = 0; i < 8; i++) begin
          hv_r[i] <= hv_r[i] + v_r[i];
        end
      end
      if (cmd.shift) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.count_inc) begin
        cnt_r <= cnt_r + 64'd1;
      end
    end
  end

  assign sts.fill    = fill_r;
  assign digest_word = hv_r[cmd.out_idx];

endmodule

@@ hdl/sha256_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha256_ctrl
// Controller: input handshake, padding sequence, round counter and digest
// output sequencing.
// ----------------------------------------------------------------------------
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_present,
  input  logic in_last,
  output logic out_tvalid,
  input  logic out_tready,
  output logic out_last,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_FFWD  = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;
  logic       mark_r, mark_nxt;
  logic       len_ok_r, len_ok_nxt;
  logic       block_full;

  assign block_full = (sts.fill == 6'(BLOCK_BYTES - 1));

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    fin_nxt    = fin_r;
    mark_nxt   = mark_r;
    len_ok_nxt = len_ok_r;
    cmd        = '0;
    cmd.rnd    = rnd_r;
    cmd.out_idx = idx_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          fin_nxt  = in_last;
          mark_nxt = 1'b0;
          if (in_present) begin
            cmd.shift     = 1'b1;
            cmd.src       = SRC_DATA;
            cmd.count_inc = 1'b1;
          end
          if (in_present && block_full) begin
            cmd.comp_load = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == 6'(ROUNDS - 1)) begin
          state_nxt = ST_FFWD;
        end
      end
      ST_FFWD: begin
        cmd.ffwd = 1'b1;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (!mark_r) begin
          state_nxt = ST_PAD;
        end else if (len_ok_r) begin
          idx_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          len_ok_nxt = 1'b1;
          state_nxt  = ST_PAD;
        end
      end
      ST_PAD: begin
        cmd.shift = 1'b1;
        if (!mark_r) begin
          cmd.src    = SRC_MARK;
          mark_nxt   = 1'b1;
          len_ok_nxt = (sts.fill < LEN_POS);
        end else if (len_ok_r && (sts.fill >= LEN_POS)) begin
          cmd.src = SRC_LEN;
        end else begin
          cmd.src = SRC_ZERO;
        end
        if (block_full) begin
          cmd.comp_load = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = ST_ROUND;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'(DIGEST_WORDS - 1)) begin
            cmd.init   = 1'b1;
            fin_nxt    = 1'b0;
            mark_nxt   = 1'b0;
            len_ok_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_last = (idx_r == 3'(DIGEST_WORDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rnd_r    <= '0;
      idx_r    <= '0;
      fin_r    <= 1'b0;
      mark_r   <= 1'b0;
      len_ok_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      fin_r    <= fin_nxt;
      mark_r   <= mark_nxt;
      len_ok_r <= len_ok_nxt;
    end
  end

endmodule

@@ hdl/sha256_message_digest_core.sv @@
// ----------------------------------------------------------------------------
// sha256_message_digest_core
// SHA-256 over a byte stream, one message byte per input beat.
//
// Input beats carry a byte in in_tdata, in_tuser marks the byte as present,
// in_tlast ends the message after this beat's byte. A beat without a byte
// and without tlast is dropped; tlast alone ends the message.
// Output: eight digest words, word 0 first, out_tlast on word 7.
// Throughput: a byte is taken every cycle until a block is full; the 64th
// byte starts a compression (64 rounds of the single round unit plus the
// feed-forward) during which in_tready is low. At the end of a message the
// padding bytes are shifted in one per cycle, each padded block followed by
// a compression; the padding fills one block, or two if the marker byte
// leaves no room for the length. The eight words go out one per accepted
// beat. in_tready stays low from the end beat until the last digest word is
// taken; a stalled receiver simply holds the word on out_tdata. Reset loads
// the initial hash values and clears both counters; afterwards the core is
// ready at once.
// ----------------------------------------------------------------------------
module sha256_message_digest_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zeros
  output logic        out_tlast   // last_word
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] digest_word;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_present (in_tuser),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_last   (out_tlast),
    .sts        (sts),
    .cmd        (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .sts         (sts),
    .digest_word (digest_word)
  );

  assign out_tdata = {5'b00000, cmd.out_idx, digest_word};

endmodule
